FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the page run allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cpra_pkg.sv
// Package: field widths, payload types, operation codes and page marks.
`timescale 1ns / 1ps

package cpra_pkg;

  localparam int OP_W    = 2;
  localparam int START_W = 11;
  localparam int COUNT_W = 12;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [START_W-1:0] page_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [1:0]         mark_t;

  // Operation codes
  localparam op_t OP_FIND   = 2'd0;
  localparam op_t OP_ALLOC  = 2'd1;
  localparam op_t OP_FREE   = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  // Page marks held in the map
  localparam mark_t MARK_UNKNOWN   = 2'd0;
  localparam mark_t MARK_FREE      = 2'd1;
  localparam mark_t MARK_ALLOCATED = 2'd2;

  typedef struct packed {
    op_t    operation;
    page_t  start_page;
    count_t page_count;
  } cpra_req_t;

  typedef struct packed {
    logic  found;
    page_t run_start;
    logic  range_error;
  } cpra_rsp_t;

endpackage

FILE: rtl/cpra_if.sv
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps

interface cpra_req_if;
  import cpra_pkg::*;

  logic      valid;
  logic      ready;
  cpra_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cpra_rsp_if;
  import cpra_pkg::*;

  logic      valid;
  logic      ready;
  cpra_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/cpra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cpra_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/contiguous_page_run_allocator.sv
// Find reads the map page by page until a run fits or the map ends; a mark writes page_count pages.
// Range errors, empty marks and code 3 touch no page and go straight to the response.
// One item at a time: the page map RAM read or write port handles one page per cycle.
// A response register lets the next request in while a result waits to be taken.
// Reset (rst, synchronous) starts a clearing pass that writes every page unknown; no request
// is taken until it is done.
`timescale 1ns / 1ps

module contiguous_page_run_allocator #(
  parameter int MAP_PAGES = 2048
) (
  input logic         clk,
  input logic         rst,
  cpra_req_if.sink    req,
  cpra_rsp_if.source  rsp
);
  import cpra_pkg::*;

  `include "assert_macros.svh"

  localparam int IW = $clog2(MAP_PAGES);
  localparam int PW = $clog2(MAP_PAGES + 1);
  localparam int CW = (PW > COUNT_W + 1) ? PW : COUNT_W + 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_MARK  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t          state, state_next;
  logic [PW-1:0]   idx, idx_next;
  logic [PW-1:0]   need, need_next;
  logic [PW-1:0]   mark_end, mark_end_next;
  mark_t           mark_val, mark_val_next;
  logic            rd_pend, rd_pend_next;
  logic [IW-1:0]   eval_idx, eval_idx_next;
  logic [PW-1:0]   base, base_next;
  logic [PW-1:0]   run_len, run_len_next;
  cpra_rsp_t       res, res_next;
  logic            out_valid, out_valid_next;
  cpra_rsp_t       out_data;
  logic            out_load;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  mark_t           ram_wdata;
  logic [IW-1:0]   ram_raddr;
  mark_t           ram_rdata;

  logic            req_fire;
  logic [CW-1:0]   need_in;
  logic [CW-1:0]   end_in;
  logic [PW-1:0]   run_len_inc;

  // Page map storage
  cpra_ram #(
    .WIDTH ($bits(mark_t)),
    .DEPTH (MAP_PAGES)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_fire    = req.valid && req.ready;
  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  // Request decode arithmetic
  assign need_in = (req.payload.page_count == '0) ? CW'(1) : CW'(req.payload.page_count);
  assign end_in  = CW'(req.payload.start_page) + CW'(req.payload.page_count);
  assign run_len_inc = run_len + PW'(1);

  // Sequencer: clear pass, first-fit scan, run write, response hand-off
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    need_next     = need;
    mark_end_next = mark_end;
    mark_val_next = mark_val;
    rd_pend_next  = rd_pend;
    eval_idx_next = eval_idx;
    base_next     = base;
    run_len_next  = run_len;
    res_next      = res;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx[IW-1:0];
    ram_wdata     = MARK_UNKNOWN;
    ram_raddr     = idx[IW-1:0];

    unique case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        idx_next = idx + PW'(1);
        if (idx == PW'(MAP_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_fire) begin
          res_next = '0;
          unique case (req.payload.operation)
            OP_FIND: begin
              if (need_in > CW'(MAP_PAGES)) begin
                state_next = S_EMIT;
              end else begin
                need_next    = PW'(need_in);
                idx_next     = '0;
                base_next    = '0;
                run_len_next = '0;
                rd_pend_next = 1'b0;
                state_next   = S_SCAN;
              end
            end
            OP_ALLOC, OP_FREE: begin
              mark_val_next = (req.payload.operation == OP_ALLOC) ? MARK_ALLOCATED
                                                                    : MARK_FREE;
              if (end_in > CW'(MAP_PAGES)) begin
                res_next.range_error = 1'b1;
                state_next           = S_EMIT;
              end else if (req.payload.page_count == '0) begin
                state_next = S_EMIT;
              end else begin
                idx_next      = PW'(req.payload.start_page);
                mark_end_next = PW'(end_in);
                state_next    = S_MARK;
              end
            end
            OP_UNUSED: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one read a cycle until the map end
        if (idx != PW'(MAP_PAGES)) begin
          rd_pend_next  = 1'b1;
          eval_idx_next = idx[IW-1:0];
          idx_next      = idx + PW'(1);
        end else begin
          rd_pend_next = 1'b0;
        end
        // evaluate the page read last cycle
        if (rd_pend) begin
          if (ram_rdata == MARK_ALLOCATED) begin
            base_next    = PW'(eval_idx) + PW'(1);
            run_len_next = '0;
            if (eval_idx == IW'(MAP_PAGES - 1)) begin
              state_next = S_EMIT;
            end
          end else begin
            run_len_next = run_len_inc;
            if (run_len_inc == need) begin
              res_next.found     = 1'b1;
              res_next.run_start = START_W'(base);
              state_next         = S_EMIT;
            end else if (eval_idx == IW'(MAP_PAGES - 1)) begin
              state_next = S_EMIT;
            end
          end
        end
      end

      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = mark_val;
        idx_next  = idx + PW'(1);
        if (idx + PW'(1) == mark_end) begin
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Response register
  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
    need     <= need_next;
    mark_end <= mark_end_next;
    mark_val <= mark_val_next;
    eval_idx <= eval_idx_next;
    base     <= base_next;
    run_len  <= run_len_next;
    res      <= res_next;
    if (out_load) begin
      out_data <= res;
    end
  end

  // Checks
  `ASSERT_IMPL(a_found_no_err, out_valid, !(out_data.found && out_data.range_error), "found with range_error")
  `ASSERT_NEXT(a_leave_idle, req_fire, state != S_IDLE, "accepted request left block idle")
  `ASSERT_IMPL(a_run_below_need, state == S_SCAN, run_len < need, "run length reached need in scan")
  `ASSERT_IMPL(a_scan_no_write, state == S_SCAN, !ram_we, "map written during scan")

endmodule

FILE: test/tb_contiguous_page_run_allocator.sv
// Testbench for the first-fit page run allocator: directed and random request beats.
`timescale 1ns / 1ps

module tb_contiguous_page_run_allocator;
  import cpra_pkg::*;

  localparam int MAP_PAGES    = 2048;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 265;

  typedef struct {
    int first;
    int length;
  } page_run_t;

  logic clk;
  logic rst;

  cpra_req_if req_if ();
  cpra_rsp_if rsp_if ();

  contiguous_page_run_allocator #(
    .MAP_PAGES(MAP_PAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Shadow copy of the page map and the replies it predicts
  mark_t     shadow_map [MAP_PAGES];
  cpra_rsp_t predicted_replies [$];
  int        error_count = 0;
  bit        no_idle = 1'b0;
  bit        hold_request = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Run lengths for well-formed traffic: mostly small, a few large
  function automatic int pick_run_length();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 32);
    return $urandom_range(33, MAP_PAGES);
  endfunction

  function automatic cpra_req_t make_req(op_t op, int start, int count);
    cpra_req_t r;
    r.operation  = op;
    r.start_page = page_t'(start);
    r.page_count = count_t'(count);
    return r;
  endfunction

  // First-fit search; a blocked candidate restarts just past the allocated page
  function automatic bit search_first_fit(int count, output int where);
    int  need;
    int  base;
    bit  blocked;
    need  = (count == 0) ? 1 : count;
    base  = 0;
    where = 0;
    if (need > MAP_PAGES) return 1'b0;
    while (base + need <= MAP_PAGES) begin
      blocked = 1'b0;
      for (int k = 0; k < need; k++) begin
        if (shadow_map[base + k] == MARK_ALLOCATED) begin
          base    = base + k + 1;
          blocked = 1'b1;
          break;
        end
      end
      if (!blocked) begin
        where = base;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the shadow map and return the reply it must produce
  function automatic cpra_rsp_t apply_to_page_map(cpra_req_t r);
    cpra_rsp_t reply;
    int        start;
    int        count;
    int        where;
    mark_t     mark;
    reply = '0;
    start = int'(r.start_page);
    count = int'(r.page_count);
    case (r.operation)
      OP_FIND: begin
        if (search_first_fit(count, where)) begin
          reply.found     = 1'b1;
          reply.run_start = page_t'(where);
        end
      end
      OP_ALLOC, OP_FREE: begin
        mark = (r.operation == OP_ALLOC) ? MARK_ALLOCATED : MARK_FREE;
        if (start > MAP_PAGES || count > MAP_PAGES - start) begin
          reply.range_error = 1'b1;
        end else begin
          for (int k = 0; k < count; k++) shadow_map[start + k] = mark;
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  // Offer one request beat; called and returning on a rising edge
  task automatic send_req(input cpra_req_t r, output cpra_rsp_t reply);
    int gap;
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk); while (!req_if.ready);
    reply = apply_to_page_map(r);
    predicted_replies.push_back(reply);
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(op_t op, int start, int count);
    cpra_rsp_t unused_reply;
    send_req(make_req(op, start, count), unused_reply);
  endtask

  // Response side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each response beat with the oldest prediction
  always @(posedge clk) begin
    cpra_rsp_t want;
    cpra_rsp_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (predicted_replies.size() == 0) begin
        $error("response beat with no request outstanding");
        error_count++;
      end else begin
        want = predicted_replies.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, got.found);
          error_count++;
        end
        if (got.run_start !== want.run_start) begin
          $error("run_start: expected %0d, actual %0d", want.run_start, got.run_start);
          error_count++;
        end
        if (got.range_error !== want.range_error) begin
          $error("range_error: expected %0d, actual %0d", want.range_error,
                 got.range_error);
          error_count++;
        end
      end
    end
  end

  // Finds on a map that is all unknown after reset
  task automatic test_empty_map_finds();
    send(OP_FIND, 0, 1);
    send(OP_FIND, 2047, 0);
    send(OP_FIND, 0, MAP_PAGES);
    send(OP_FIND, 0, MAP_PAGES + 1);
    send(OP_FIND, 0, 4095);
  endtask

  // Marks at the map edges, empty marks and marks past the end
  task automatic test_mark_extremes();
    send(OP_ALLOC, 2047, 1);
    send(OP_FIND, 0, MAP_PAGES);
    send(OP_ALLOC, 2047, 2);
    send(OP_FREE, 2047, 0);
    send(OP_ALLOC, 0, MAP_PAGES);
    send(OP_FIND, 0, 1);
    send(OP_FREE, 0, MAP_PAGES);
    send(OP_FIND, 0, MAP_PAGES);
  endtask

  // An allocated page pushes the next candidate just past itself
  task automatic test_blocked_restart();
    send(OP_ALLOC, 5, 1);
    send(OP_FIND, 0, 6);
    send(OP_FIND, 0, 5);
    send(OP_FREE, 5, 1);
  endtask

  // Code 3 changes nothing and returns all zeros
  task automatic test_unused_op();
    send(OP_UNUSED, 2047, 4095);
    send(OP_UNUSED, 0, 0);
  endtask

  // Long response hold-off while requests keep coming
  task automatic test_backpressure();
    no_idle      = 1'b1;
    hold_request = 1'b1;
    send(OP_ALLOC, 100, 1);
    send(OP_FIND, 0, 1);
    send(OP_FREE, 100, 1);
    send(OP_FIND, 0, 2);
    send(OP_ALLOC, 0, 1);
    send(OP_FIND, 0, 1);
    no_idle = 1'b0;
  endtask

  // Mostly find-then-allocate and free of live runs, plus noise
  task automatic test_random_traffic();
    page_run_t live [$];
    page_run_t run;
    cpra_rsp_t reply;
    int        sent;
    int        pick;
    int        idx;
    int        count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (live.size() > 40) pick = 50;
      if (pick < 45) begin
        count = pick_run_length();
        send_req(make_req(OP_FIND, $urandom_range(0, 2047), count), reply);
        sent++;
        if (reply.found) begin
          run.first  = int'(reply.run_start);
          run.length = count;
          send_req(make_req(OP_ALLOC, run.first, count), reply);
          live.push_back(run);
          sent++;
        end
      end else if (pick < 75 && live.size() > 0) begin
        idx = $urandom_range(0, live.size() - 1);
        run = live[idx];
        live.delete(idx);
        send(OP_FREE, run.first, run.length);
        sent++;
      end else if (pick < 88) begin
        send(OP_FIND, $urandom_range(0, 2047), $urandom_range(0, 4095));
        sent++;
      end else if (pick < 96) begin
        send(($urandom_range(0, 1) == 0) ? OP_ALLOC : OP_FREE,
             $urandom_range(0, 2047), $urandom_range(0, 4095));
        sent++;
      end else begin
        send(OP_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 4095));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // Main sequence
  initial begin
    foreach (shadow_map[i]) shadow_map[i] = MARK_UNKNOWN;
    rst            <= 1'b1;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_map_finds();
    test_mark_extremes();
    test_blocked_restart();
    test_unused_op();
    test_backpressure();
    test_random_traffic();

    req_if.valid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (MAP_PAGES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
